// File: hw/rtl/scope_edge_trigger_capture_macros.svh
// Assertion macros for the scope edge trigger capture block.
`ifndef SCOPE_EDGE_TRIGGER_CAPTURE_MACROS_SVH
`define SCOPE_EDGE_TRIGGER_CAPTURE_MACROS_SVH

// Same-cycle implication, held off during reset.
`define SEC_ASSERT_NOW(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
    else $error("sec: same-cycle check failed");

// Next-cycle implication, held off during reset.
`define SEC_ASSERT_NEXT(label, clock, reset, cond, expr) \
  label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
    else $error("sec: next-cycle check failed");

`endif

// File: hw/rtl/sec_pkg.sv
// Shared widths, register indexes and reset values for the scope edge trigger capture.
`timescale 1ns / 1ps

package sec_pkg;

  localparam int SAMPLE_W = 12;
  localparam int INDEX_W  = 9;
  localparam int Y_W      = 8;
  localparam int ZOOM_W   = 4;
  localparam int CFG_IDX_W = 1;

  // log2 of the ADC span (4096 codes)
  localparam int SPAN_SHIFT = 12;

  localparam logic [SAMPLE_W-1:0] THRESHOLD_RESET = 12'd2048;
  localparam logic [ZOOM_W-1:0]   ZOOM_MIN        = 4'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER_ON_RISING = 1'b0,
    REG_JUMP_LIMIT        = 1'b1
  } cfg_reg_t;

endpackage

// File: hw/rtl/scope_edge_trigger_capture.sv
// Top level of the scope edge trigger capture: edge detect, frame capture and zoom control.
`timescale 1ns / 1ps
//
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------------
//  in       | in_valid / in_ready    | sample, zoom_out_press, zoom_in_press
//  out      | out_valid / out_ready  | point_valid, point_index, point_y, frame_done,
//           |                        | rising_seen, falling_seen, zoom_level, rate_changed
//  config   | wr_en (no wait)        | wr_index, wr_data
//
//  One item per cycle sustained while out is not stalled; an item passes the input register,
//  then the single edge-compare / row-scale / capture-count pass, into the result register.
//  Reset (rst, synchronous): idle awaiting trigger, previous sample zero, zoom 1,
//  falling-edge trigger, threshold 2048.
//  A stall on out holds the result register; the input register still takes one
//  item, after which in_ready drops until the result moves on.

`include "scope_edge_trigger_capture_macros.svh"

module scope_edge_trigger_capture #(
  parameter int FRAME_POINTS = 320,
  parameter int SCREEN_ROWS  = 240,
  parameter int MAX_ZOOM     = 8
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [sec_pkg::SAMPLE_W-1:0]         sample,
  input  logic                                 zoom_out_press,
  input  logic                                 zoom_in_press,
  // output channel
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 point_valid,
  output logic [sec_pkg::INDEX_W-1:0]          point_index,
  output logic [sec_pkg::Y_W-1:0]              point_y,
  output logic                                 frame_done,
  output logic                                 rising_seen,
  output logic                                 falling_seen,
  output logic [sec_pkg::ZOOM_W-1:0]           zoom_level,
  output logic                                 rate_changed,
  // configuration writes
  input  logic                                 wr_en,
  input  logic [sec_pkg::CFG_IDX_W-1:0]        wr_index,
  input  logic [sec_pkg::SAMPLE_W-1:0]         wr_data
);

  // Position counter must hold FRAME_POINTS itself (the frame-end marker).
  localparam int POS_W  = $clog2(FRAME_POINTS + 1);
  localparam int ROW_W  = $clog2(SCREEN_ROWS + 1);
  localparam int PROD_W = sec_pkg::SAMPLE_W + ROW_W;

  localparam logic [POS_W-1:0]           FRAME_END = POS_W'(FRAME_POINTS);
  localparam logic [ROW_W-1:0]           ROWS_K    = ROW_W'(SCREEN_ROWS);
  localparam logic [sec_pkg::ZOOM_W-1:0] ZOOM_MAX  = sec_pkg::ZOOM_W'(MAX_ZOOM);

  // ---------------------------------------------------------------- config registers
  logic                         trigger_on_rising;
  logic [sec_pkg::SAMPLE_W-1:0] jump_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_on_rising <= 1'b0;
      jump_limit        <= sec_pkg::THRESHOLD_RESET;
    end else if (wr_en) begin
      case (wr_index)
        sec_pkg::REG_TRIGGER_ON_RISING: trigger_on_rising <= wr_data[0];
        sec_pkg::REG_JUMP_LIMIT:        jump_limit        <= wr_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input register
  logic                         s1_valid;
  logic [sec_pkg::SAMPLE_W-1:0] s1_sample;
  logic                         s1_zout;
  logic                         s1_zin;
  logic                         advance;

  // Move the held item into the result register whenever that register is free
  // or being emptied this cycle.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_sample <= sample;
      s1_zout   <= zoom_out_press;
      s1_zin    <= zoom_in_press;
    end
  end

  // ---------------------------------------------------------------- processing state
  logic [sec_pkg::SAMPLE_W-1:0] previous_sample;
  logic [POS_W-1:0]             write_position;
  logic [sec_pkg::ZOOM_W-1:0]   zoom_state;

  logic [sec_pkg::SAMPLE_W-1:0] previous_sample_next;
  logic [POS_W-1:0]             write_position_next;
  logic [sec_pkg::ZOOM_W-1:0]   zoom_state_next;

  // ---------------------------------------------------------------- edge detect
  // Sums carry one extra bit so threshold plus sample never wraps.
  logic [sec_pkg::SAMPLE_W:0] prev_plus_thr;
  logic [sec_pkg::SAMPLE_W:0] cur_plus_thr;
  logic                       rise;
  logic                       fall;

  assign prev_plus_thr = {1'b0, previous_sample} + {1'b0, jump_limit};
  assign cur_plus_thr  = {1'b0, s1_sample} + {1'b0, jump_limit};
  assign rise = {1'b0, s1_sample} > prev_plus_thr;
  // Falling only counts when the sample is not already a rising edge.
  assign fall = !rise && (cur_plus_thr < {1'b0, previous_sample});

  // ---------------------------------------------------------------- screen row
  // row = ROWS - sample*ROWS/4096; the divide is a right shift by the span bits.
  logic [PROD_W-1:0] row_prod;
  logic [ROW_W-1:0]  row_scaled;
  logic [ROW_W-1:0]  row;

  assign row_prod   = PROD_W'(s1_sample) * PROD_W'(ROWS_K);
  assign row_scaled = row_prod[PROD_W-1:sec_pkg::SPAN_SHIFT];
  assign row        = ROWS_K - row_scaled;

  // ---------------------------------------------------------------- zoom
  // Apply zoom out first, then zoom in, each saturating.
  logic [sec_pkg::ZOOM_W-1:0] zoom_after_out;

  always_comb begin
    zoom_after_out = zoom_state;
    if (s1_zout && (zoom_state < ZOOM_MAX)) begin
      zoom_after_out = zoom_state + sec_pkg::ZOOM_W'(1);
    end
    zoom_state_next = zoom_after_out;
    if (s1_zin && (zoom_after_out > sec_pkg::ZOOM_MIN)) begin
      zoom_state_next = zoom_after_out - sec_pkg::ZOOM_W'(1);
    end
  end

  // ---------------------------------------------------------------- capture control
  logic             trig_hit;
  logic             rec_valid;
  logic             rec_done;
  logic [POS_W-1:0] rec_index;

  assign trig_hit             = trigger_on_rising ? rise : fall;
  assign previous_sample_next = s1_sample;

  always_comb begin
    rec_valid           = 1'b0;
    rec_done            = 1'b0;
    rec_index           = '0;
    write_position_next = write_position;
    if (write_position == '0) begin
      // Idle: a matching edge records point zero and opens the frame.
      if (trig_hit) begin
        rec_valid           = 1'b1;
        write_position_next = POS_W'(1);
      end
    end else if (write_position >= FRAME_END) begin
      // Frame full: drop this sample and go back to waiting for a trigger.
      rec_done            = 1'b1;
      write_position_next = '0;
    end else begin
      rec_valid           = 1'b1;
      rec_index           = write_position;
      write_position_next = write_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_sample <= '0;
      write_position  <= '0;
      zoom_state      <= sec_pkg::ZOOM_MIN;
    end else if (advance) begin
      previous_sample <= previous_sample_next;
      write_position  <= write_position_next;
      zoom_state      <= zoom_state_next;
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      point_valid  <= rec_valid;
      point_index  <= sec_pkg::INDEX_W'(rec_index);
      point_y      <= rec_valid ? sec_pkg::Y_W'(row) : '0;
      frame_done   <= rec_done;
      rising_seen  <= rise;
      falling_seen <= fall;
      zoom_level   <= zoom_state_next;
      rate_changed <= s1_zout || s1_zin;
    end
  end

  // ---------------------------------------------------------------- assertions
  `SEC_ASSERT_NOW(a_point_xor_done, clk, rst, out_valid, !(point_valid && frame_done))
  `SEC_ASSERT_NOW(a_one_edge_kind, clk, rst, out_valid, !(rising_seen && falling_seen))
  `SEC_ASSERT_NOW(a_pos_in_frame, clk, rst, 1'b1, write_position <= FRAME_END)
  `SEC_ASSERT_NOW(a_zoom_in_range, clk, rst, 1'b1,
                  zoom_state >= sec_pkg::ZOOM_MIN && zoom_state <= ZOOM_MAX)
  `SEC_ASSERT_NEXT(a_stall_holds_pos, clk, rst, out_valid && !out_ready, $stable(write_position))

endmodule
